[rtl/core/rrsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrsp_pkg
// shared types, constants and tables for the rotated rectangle support point
// ----------------------------------------------------------------------------
package rrsp_pkg;

	// angle codes, degrees with 6 fractional bits
	localparam logic signed [16:0] ANGLE_FULL    = 17'sd23040;
	localparam logic signed [16:0] ANGLE_HALF    = 17'sd11520;
	localparam logic signed [16:0] ANGLE_QUARTER = 17'sd5760;

	localparam int CORDIC_STEPS = 16;

	// cordic datapath widths
	localparam int XW = 20;
	localparam int ZW = 26;

	localparam logic signed [XW-1:0] CORDIC_GAIN_INIT = 20'sd39797;
	localparam logic signed [XW-1:0] TRIG_ONE_X       = 20'sd65536;
	localparam logic signed [17:0]   TRIG_ONE         = 18'sd65536;

	// atan(2^-i) in degrees q16
	localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
		26'sd14667,   26'sd7334,    26'sd3667,   26'sd1833,
		26'sd917,     26'sd458,     26'sd229,    26'sd115
	};

	// corner codes
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	// axis class of the folded angle; exact axes override the cordic result
	typedef enum logic [1:0] {
		AXIS_NONE,
		AXIS_ZERO,
		AXIS_POS,
		AXIS_NEG
	} axis_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic        [11:0] rect_width;
		logic        [11:0] rect_height;
		logic signed [15:0] rotation;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} query_t;

	typedef struct packed {
		logic signed [23:0] far_x;
		logic signed [23:0] far_y;
		logic        [1:0]  far_corner;
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
	} result_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic        [11:0] w;
		logic        [11:0] h;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} geo_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
		axis_t                axis;
		geo_t                 geo;
	} cor_t;

	// rounded q8 corners and centre
	typedef struct packed {
		logic [3:0][25:0] cx;
		logic [3:0][25:0] cy;
		logic [25:0]      cen_x;
		logic [25:0]      cen_y;
	} pts_t;

endpackage
`default_nettype wire

[rtl/core/rotated_rect_support_point.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_rect_support_point
// support point (farthest corner along a direction) and centre of a rotated
// rectangle, cordic sine/cosine, fully pipelined
// ----------------------------------------------------------------------------
//  channel | signals                             | payload
//  query   | query_valid, query_stall (out)      | rrsp_pkg::query_t
//  result  | result_valid, result_stall (in)     | rrsp_pkg::result_t
//
//  one query per cycle while query_stall is low
//  the pipe is the 16-stage unrolled cordic plus 9 datapath stages
//  reset clears only the stage valid bits, payload registers are free running
//  each stage holds while it is full and the stage after it cannot take;
//  empty stages keep filling, so bubbles collapse under a result stall
//  query_stall rises only when all 25 stages hold items
// ----------------------------------------------------------------------------
module rotated_rect_support_point (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               query_valid,
	output      logic               query_stall,
	input  wire rrsp_pkg::query_t   query,
	output      logic               result_valid,
	input  wire logic               result_stall,
	output      rrsp_pkg::result_t  result
);

	localparam int NS = 25;      // pipeline depth
	localparam int ST_TRIG  = 17;
	localparam int ST_MUL   = 18;
	localparam int ST_SUM   = 19;
	localparam int ST_Q8    = 20;
	localparam int ST_DOT   = 21;
	localparam int ST_SCORE = 22;
	localparam int ST_CMP   = 23;
	localparam int ST_OUT   = 24;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;

	// stage k may load when it is empty or its content moves on
	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || !result_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign query_stall  = !adv[0];
	assign result_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= query_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ---------------- stage 0: angle reduction and fold ----------------
	// wrap into [-180, 180) then fold into [-90, 90]; folding by 180 flips sign
	logic signed [16:0]  rot_w, rot_m, rot_f;
	logic                neg0;
	rrsp_pkg::axis_t     axis0;
	rrsp_pkg::cor_t      cor_in;

	always_comb begin
		rot_w = 17'(query.rotation);
		if (rot_w >= rrsp_pkg::ANGLE_HALF) begin
			rot_m = rot_w - rrsp_pkg::ANGLE_FULL;
		end else if (rot_w < -rrsp_pkg::ANGLE_HALF) begin
			rot_m = rot_w + rrsp_pkg::ANGLE_FULL;
		end else begin
			rot_m = rot_w;
		end
		neg0 = 1'b0;
		if (rot_m > rrsp_pkg::ANGLE_QUARTER) begin
			rot_f = rot_m - rrsp_pkg::ANGLE_HALF;
			neg0  = 1'b1;
		end else if (rot_m < -rrsp_pkg::ANGLE_QUARTER) begin
			rot_f = rot_m + rrsp_pkg::ANGLE_HALF;
			neg0  = 1'b1;
		end else begin
			rot_f = rot_m;
		end
		// exact axes skip the cordic result
		if (rot_f == 17'sd0) begin
			axis0 = rrsp_pkg::AXIS_ZERO;
		end else if (rot_f == rrsp_pkg::ANGLE_QUARTER) begin
			axis0 = rrsp_pkg::AXIS_POS;
		end else if (rot_f == -rrsp_pkg::ANGLE_QUARTER) begin
			axis0 = rrsp_pkg::AXIS_NEG;
		end else begin
			axis0 = rrsp_pkg::AXIS_NONE;
		end
		cor_in.x = rrsp_pkg::CORDIC_GAIN_INIT;
		cor_in.y = '0;
		// degrees q6 to degrees q16
		cor_in.z = $signed({rot_f[15:0], 10'd0});
		cor_in.neg  = neg0;
		cor_in.axis = axis0;
		cor_in.geo.pos_x = query.pos_x;
		cor_in.geo.pos_y = query.pos_y;
		cor_in.geo.w     = query.rect_width;
		cor_in.geo.h     = query.rect_height;
		cor_in.geo.dx    = query.dir_x;
		cor_in.geo.dy    = query.dir_y;
	end

	rrsp_pkg::cor_t cor_s [rrsp_pkg::CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cor_s[0] <= cor_in;
		end
	end

	// ---------------- stages 1..16: one cordic rotation each ----------------
	for (genvar i = 0; i < rrsp_pkg::CORDIC_STEPS; i++) begin : g_cordic
		rrsp_pkg::cor_t               nxt;
		logic signed [rrsp_pkg::XW-1:0] xs, ys;

		always_comb begin
			nxt = cor_s[i];
			xs  = cor_s[i].x >>> i;
			ys  = cor_s[i].y >>> i;
			if (!cor_s[i].z[rrsp_pkg::ZW-1]) begin
				nxt.x = cor_s[i].x - ys;
				nxt.y = cor_s[i].y + xs;
				nxt.z = cor_s[i].z - rrsp_pkg::ATAN_DEG_Q16[i];
			end else begin
				nxt.x = cor_s[i].x + ys;
				nxt.y = cor_s[i].y - xs;
				nxt.z = cor_s[i].z + rrsp_pkg::ATAN_DEG_Q16[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				cor_s[i+1] <= nxt;
			end
		end
	end

	// ---------------- stage 17: clamp, axis override, sign flip ----------------
	typedef struct packed {
		logic signed [17:0] sin_v;
		logic signed [17:0] cos_v;
		rrsp_pkg::geo_t     geo;
	} trig_t;

	trig_t                trig_d, trig_s17;
	rrsp_pkg::cor_t       cor_f;
	logic signed [17:0]   cos_cl, sin_cl;

	always_comb begin
		cor_f = cor_s[rrsp_pkg::CORDIC_STEPS];
		if (cor_f.x > rrsp_pkg::TRIG_ONE_X) begin
			cos_cl = rrsp_pkg::TRIG_ONE;
		end else if (cor_f.x < -rrsp_pkg::TRIG_ONE_X) begin
			cos_cl = -rrsp_pkg::TRIG_ONE;
		end else begin
			cos_cl = cor_f.x[17:0];
		end
		if (cor_f.y > rrsp_pkg::TRIG_ONE_X) begin
			sin_cl = rrsp_pkg::TRIG_ONE;
		end else if (cor_f.y < -rrsp_pkg::TRIG_ONE_X) begin
			sin_cl = -rrsp_pkg::TRIG_ONE;
		end else begin
			sin_cl = cor_f.y[17:0];
		end
		case (cor_f.axis)
			rrsp_pkg::AXIS_ZERO: begin
				trig_d.cos_v = rrsp_pkg::TRIG_ONE;
				trig_d.sin_v = '0;
			end
			rrsp_pkg::AXIS_POS: begin
				trig_d.cos_v = '0;
				trig_d.sin_v = rrsp_pkg::TRIG_ONE;
			end
			rrsp_pkg::AXIS_NEG: begin
				trig_d.cos_v = '0;
				trig_d.sin_v = -rrsp_pkg::TRIG_ONE;
			end
			default: begin
				trig_d.cos_v = cos_cl;
				trig_d.sin_v = sin_cl;
			end
		endcase
		if (cor_f.neg) begin
			trig_d.cos_v = -trig_d.cos_v;
			trig_d.sin_v = -trig_d.sin_v;
		end
		trig_d.geo = cor_f.geo;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_TRIG]) begin
			trig_s17 <= trig_d;
		end
	end

	// ---------------- stage 18: size times trig products ----------------
	typedef struct packed {
		logic signed [30:0] wc, ws, hc, hs;    // full size
		logic signed [30:0] wc2, ws2, hc2, hs2; // truncated half size
		rrsp_pkg::geo_t     geo;
	} mul_t;

	mul_t               mul_d, mul_s18;
	logic signed [12:0] w_f, h_f, w_h, h_h;

	always_comb begin
		w_f = $signed({1'b0, trig_s17.geo.w});
		h_f = $signed({1'b0, trig_s17.geo.h});
		w_h = $signed({2'b00, trig_s17.geo.w[11:1]});
		h_h = $signed({2'b00, trig_s17.geo.h[11:1]});
		mul_d.wc  = 31'(w_f) * 31'(trig_s17.cos_v);
		mul_d.ws  = 31'(w_f) * 31'(trig_s17.sin_v);
		mul_d.hc  = 31'(h_f) * 31'(trig_s17.cos_v);
		mul_d.hs  = 31'(h_f) * 31'(trig_s17.sin_v);
		mul_d.wc2 = 31'(w_h) * 31'(trig_s17.cos_v);
		mul_d.ws2 = 31'(w_h) * 31'(trig_s17.sin_v);
		mul_d.hc2 = 31'(h_h) * 31'(trig_s17.cos_v);
		mul_d.hs2 = 31'(h_h) * 31'(trig_s17.sin_v);
		mul_d.geo = trig_s17.geo;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			mul_s18 <= mul_d;
		end
	end

	// ---------------- stage 19: exact q16 corner sums ----------------
	typedef struct packed {
		logic [3:1][33:0]   vx;
		logic [3:1][33:0]   vy;
		logic signed [33:0] cen_x;
		logic signed [33:0] cen_y;
		rrsp_pkg::geo_t     geo;
	} sum_t;

	sum_t               sum_d, sum_s19;
	logic signed [33:0] px, py;

	always_comb begin
		px = 34'($signed({mul_s18.geo.pos_x, 8'd0}));
		py = 34'($signed({mul_s18.geo.pos_y, 8'd0}));
		sum_d.vx[1] = px + 34'(mul_s18.wc);
		sum_d.vy[1] = py + 34'(mul_s18.ws);
		sum_d.vx[2] = px + 34'(mul_s18.wc) - 34'(mul_s18.hs);
		sum_d.vy[2] = py + 34'(mul_s18.ws) + 34'(mul_s18.hc);
		sum_d.vx[3] = px - 34'(mul_s18.hs);
		sum_d.vy[3] = py + 34'(mul_s18.hc);
		sum_d.cen_x = px + 34'(mul_s18.wc2) - 34'(mul_s18.hs2);
		sum_d.cen_y = py + 34'(mul_s18.ws2) + 34'(mul_s18.hc2);
		sum_d.geo   = mul_s18.geo;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SUM]) begin
			sum_s19 <= sum_d;
		end
	end

	// ---------------- stage 20: round to q8 (add half, floor) ----------------
	typedef struct packed {
		rrsp_pkg::pts_t     pts;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} q8_t;

	q8_t         q8_d, q8_s20;
	logic [33:0] rx [3:1];
	logic [33:0] ry [3:1];
	logic [33:0] rcx, rcy;

	always_comb begin
		for (int k = 1; k < 4; k++) begin
			rx[k] = sum_s19.vx[k] + 34'd128;
			ry[k] = sum_s19.vy[k] + 34'd128;
			q8_d.pts.cx[k] = rx[k][33:8];
			q8_d.pts.cy[k] = ry[k][33:8];
		end
		// top-left corner is the position itself
		q8_d.pts.cx[0] = 26'($signed(sum_s19.geo.pos_x));
		q8_d.pts.cy[0] = 26'($signed(sum_s19.geo.pos_y));
		rcx = sum_s19.cen_x + 34'sd128;
		rcy = sum_s19.cen_y + 34'sd128;
		q8_d.pts.cen_x = rcx[33:8];
		q8_d.pts.cen_y = rcy[33:8];
		q8_d.dx = sum_s19.geo.dx;
		q8_d.dy = sum_s19.geo.dy;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_Q8]) begin
			q8_s20 <= q8_d;
		end
	end

	// ---------------- stage 21: dot product terms ----------------
	typedef struct packed {
		logic [3:0][41:0] tx;
		logic [3:0][41:0] ty;
		rrsp_pkg::pts_t   pts;
	} dot_t;

	dot_t dot_d, dot_s21;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dot_d.tx[k] = 42'(q8_s20.dx) * 42'($signed(q8_s20.pts.cx[k]));
			dot_d.ty[k] = 42'(q8_s20.dy) * 42'($signed(q8_s20.pts.cy[k]));
		end
		dot_d.pts = q8_s20.pts;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_DOT]) begin
			dot_s21 <= dot_d;
		end
	end

	// ---------------- stage 22: scores ----------------
	typedef struct packed {
		logic [3:0][42:0] sc;
		rrsp_pkg::pts_t   pts;
	} score_t;

	score_t score_d, score_s22;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			score_d.sc[k] = 43'($signed(dot_s21.tx[k])) + 43'($signed(dot_s21.ty[k]));
		end
		score_d.pts = dot_s21.pts;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SCORE]) begin
			score_s22 <= score_d;
		end
	end

	// ---------------- stage 23: pairwise compare ----------------
	// first max of each pair; later one wins only when strictly greater
	typedef struct packed {
		logic [1:0]       p01;
		logic [1:0]       p23;
		logic [42:0]      b01;
		logic [42:0]      b23;
		rrsp_pkg::pts_t   pts;
	} cmp_t;

	cmp_t cmp_d, cmp_s23;

	always_comb begin
		if ($signed(score_s22.sc[1]) > $signed(score_s22.sc[0])) begin
			cmp_d.p01 = rrsp_pkg::CORNER_TR;
			cmp_d.b01 = score_s22.sc[1];
		end else begin
			cmp_d.p01 = rrsp_pkg::CORNER_TL;
			cmp_d.b01 = score_s22.sc[0];
		end
		if ($signed(score_s22.sc[3]) > $signed(score_s22.sc[2])) begin
			cmp_d.p23 = rrsp_pkg::CORNER_BL;
			cmp_d.b23 = score_s22.sc[3];
		end else begin
			cmp_d.p23 = rrsp_pkg::CORNER_BR;
			cmp_d.b23 = score_s22.sc[2];
		end
		cmp_d.pts = score_s22.pts;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_CMP]) begin
			cmp_s23 <= cmp_d;
		end
	end

	// ---------------- stage 24: final pick, saturate, output register ----------------
	function automatic logic [23:0] sat24(input logic signed [25:0] v);
		logic [23:0] r;
		if (v > 26'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (v < -26'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	rrsp_pkg::result_t res_d, res_s24;
	logic [1:0]        pick;

	always_comb begin
		if ($signed(cmp_s23.b23) > $signed(cmp_s23.b01)) begin
			pick = cmp_s23.p23;
		end else begin
			pick = cmp_s23.p01;
		end
		res_d.far_x      = sat24($signed(cmp_s23.pts.cx[pick]));
		res_d.far_y      = sat24($signed(cmp_s23.pts.cy[pick]));
		res_d.far_corner = pick;
		res_d.center_x   = sat24($signed(cmp_s23.pts.cen_x));
		res_d.center_y   = sat24($signed(cmp_s23.pts.cen_y));
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			res_s24 <= res_d;
		end
	end

	assign result = res_s24;

endmodule
`default_nettype wire

[rtl/core/rrsp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrsp_checker
// port-level checks for the rotated rectangle support point
// ----------------------------------------------------------------------------
module rrsp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              query_valid,
	input wire logic              query_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire rrsp_pkg::result_t result
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// query side only backs up when the result is valid and stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> result_valid && result_stall)
		else $error("query stalled with room in the pipe");

	// reset empties the pipe
	a_reset: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind rotated_rect_support_point rrsp_checker u_rrsp_checker (.*);
`default_nettype wire
